@@ design/q24_8_fixed_point_alu_core_assert.svh @@
// Assertion macros shared by the RTL of the Q24.8 ALU core
`ifndef Q24_8_FIXED_POINT_ALU_CORE_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_CORE_ASSERT_SVH

// Implication checked at the same edge
`define Q24A_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("q24a: assertion failed");

// Implication checked at the next edge
`define Q24A_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("q24a: assertion failed");

`endif

@@ design/q24a_pkg.sv @@
package q24a_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV  = 4'd3,
    OP_GT   = 4'd4,  OP_LT   = 4'd5,  OP_GE   = 4'd6,  OP_LE   = 4'd7,
    OP_EQ   = 4'd8,  OP_NE   = 4'd9,  OP_MIN  = 4'd10, OP_MAX  = 4'd11,
    OP_INC  = 4'd12, OP_DEC  = 4'd13, OP_FINT = 4'd14, OP_TINT = 4'd15
  } opcode_e;

  localparam int unsigned CmdBits = 4;
  localparam int unsigned FlagBits = 3;

  // Per-item control travelling down the pipeline
  typedef struct packed {
    opcode_e cmd;
    logic    a_neg;
    logic    neg;
    logic    b_zero;
    logic    cmp;
    logic    dz;
    logic    sat;
  } lane_t;

endpackage

@@ design/q24_8_fixed_point_alu_core.sv @@
// Channel   | Dir | tdata (low bit up)                | tuser (low bit up)
// s_axis    | in  | cmd[3:0], operand_a, operand_b    | -
// m_axis    | out | result_value                      | compare_true, divide_by_zero,
//           |     |                                   | saturated
// Every opcode passes through the same pipeline depth; one transfer is accepted per
// cycle unless the output stalls. The depth is set by the divider, which resolves one
// quotient bit per stage. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall freezes every stage in place.
// Reset clears the valid bits only.
module q24_8_fixed_point_alu_core #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // cmd, operand_a, operand_b, zero fill
  input  logic [((2*WORD_BITS+4+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // result_value, zero fill
  output logic [((WORD_BITS+7)/8)*8-1:0]         m_axis_tdata_o,
  // compare_true, divide_by_zero, saturated
  output logic [q24a_pkg::FlagBits-1:0]          m_axis_tuser_o
);
  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned N     = W + F;
  localparam int unsigned P     = N + 2;
  localparam int unsigned H     = W / 2;
  localparam int unsigned HI    = W - H;
  localparam int unsigned SW    = 2 * W + F + 1;
  localparam int unsigned OUTB  = ((W + 7) / 8) * 8;

  // Sign and clamp a magnitude; returns {sat, word}
  function automatic logic [W:0] sign_sat(input logic [SW-1:0] mag, input logic neg);
    logic [SW-1:0] lim;
    lim = SW'(1) << (W - 1);
    if (neg) begin
      if (mag > lim) sign_sat = {1'b1, 1'b1, {(W-1){1'b0}}};
      else           sign_sat = {1'b0, W'(~mag + SW'(1))};
    end else begin
      if (mag > lim - SW'(1)) sign_sat = {1'b1, 1'b0, {(W-1){1'b1}}};
      else                    sign_sat = {1'b0, W'(mag)};
    end
  endfunction

  logic                en;
  logic [P-1:0]        vld_q;
  q24a_pkg::lane_t     ctl_q [P];
  logic [W-1:0]        res_q [P];
  logic [W-1:0]        ma_q, mb_q;
  logic [W+H-1:0]      pp_lo_q;
  logic [W+HI-1:0]     pp_hi_q;

  assign en = !vld_q[P-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input stage decode
  logic [q24a_pkg::CmdBits-1:0] in_cmd;
  logic [W-1:0]    a, b, a_mag, b_mag, to_int_m;
  logic [W:0]      to_int_r;
  logic            lt, gt;
  logic [W-1:0]    res0;
  q24a_pkg::lane_t ctl0;

  assign in_cmd = s_axis_tdata_i[q24a_pkg::CmdBits-1:0];
  assign a      = s_axis_tdata_i[q24a_pkg::CmdBits +: W];
  assign b      = s_axis_tdata_i[q24a_pkg::CmdBits + W +: W];
  assign a_mag  = a[W-1] ? W'(~a + W'(1)) : a;
  assign b_mag  = b[W-1] ? W'(~b + W'(1)) : b;
  assign lt     = $signed(a) < $signed(b);
  assign gt     = $signed(a) > $signed(b);
  assign to_int_r = ({1'b0, a_mag} + ((W+1)'(1) << (F - 1))) >> F;
  assign to_int_m = W'(to_int_r);

  always_comb begin
    ctl0 = '0;
    ctl0.cmd    = q24a_pkg::opcode_e'(in_cmd);
    ctl0.a_neg  = a[W-1];
    ctl0.neg    = a[W-1] ^ b[W-1];
    ctl0.b_zero = (b == '0);
    res0 = '0;
    unique case (ctl0.cmd)
      q24a_pkg::OP_ADD:  res0 = a + b;
      q24a_pkg::OP_SUB:  res0 = a - b;
      q24a_pkg::OP_MUL:  res0 = '0;
      q24a_pkg::OP_DIV:  res0 = '0;
      q24a_pkg::OP_GT:   ctl0.cmp = gt;
      q24a_pkg::OP_LT:   ctl0.cmp = lt;
      q24a_pkg::OP_GE:   ctl0.cmp = !lt;
      q24a_pkg::OP_LE:   ctl0.cmp = !gt;
      q24a_pkg::OP_EQ:   ctl0.cmp = (a == b);
      q24a_pkg::OP_NE:   ctl0.cmp = (a != b);
      q24a_pkg::OP_MIN:  res0 = lt ? a : b;
      q24a_pkg::OP_MAX:  res0 = gt ? a : b;
      q24a_pkg::OP_INC:  res0 = a + W'(1);
      q24a_pkg::OP_DEC:  res0 = a - W'(1);
      q24a_pkg::OP_FINT: res0 = a << F;
      q24a_pkg::OP_TINT: res0 = a[W-1] ? W'(~to_int_m + W'(1)) : to_int_m;
      default:           res0 = '0;
    endcase
  end

  // Multiply: partial products in stage 1, sum and round into stage 2
  logic [2*W-1:0]  prod;
  logic [SW-1:0]   mul_r;
  logic [W:0]      mul_s;
  assign prod  = (2*W)'(pp_lo_q) + ((2*W)'(pp_hi_q) << H);
  assign mul_r = (SW'(prod) + (SW'(1) << (F - 1))) >> F;
  assign mul_s = sign_sat(mul_r, ctl_q[1].neg);

  // Divide: round half up on the remainder, then clamp
  logic [N-1:0]    quot;
  logic [W-1:0]    rem, dsr;
  logic [SW-1:0]   div_q;
  logic [W:0]      div_s;
  q24a_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
    .clk_i     (clk_i),
    .en_i      (en),
    .mag_a_i   (ma_q),
    .mag_b_i   (mb_q),
    .quot_o    (quot),
    .rem_o     (rem),
    .divisor_o (dsr)
  );
  assign div_q = SW'(quot) + SW'({rem, 1'b0} >= {1'b0, dsr});
  assign div_s = sign_sat(div_q, ctl_q[N].neg);

  // Stage contents where multiply and divide results drop in
  q24a_pkg::lane_t ctl_mul_d, ctl_div_d;
  logic [W-1:0]    res_mul_d, res_div_d;

  always_comb begin
    ctl_mul_d = ctl_q[1];
    res_mul_d = res_q[1];
    if (ctl_q[1].cmd == q24a_pkg::OP_MUL) begin
      res_mul_d     = mul_s[W-1:0];
      ctl_mul_d.sat = mul_s[W];
    end
    ctl_div_d = ctl_q[N];
    res_div_d = res_q[N];
    if (ctl_q[N].cmd == q24a_pkg::OP_DIV) begin
      if (ctl_q[N].b_zero) begin
        res_div_d     = ctl_q[N].a_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        ctl_div_d.dz  = 1'b1;
        ctl_div_d.sat = 1'b1;
      end else begin
        res_div_d     = div_s[W-1:0];
        ctl_div_d.sat = div_s[W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[P-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= ctl0;
      res_q[0] <= res0;
      ma_q     <= a_mag;
      mb_q     <= b_mag;
      pp_lo_q  <= ma_q * mb_q[H-1:0];
      pp_hi_q  <= ma_q * mb_q[W-1:H];
      for (int s = 1; s < P; s++) begin
        if (s == 2) begin
          ctl_q[s] <= ctl_mul_d;
          res_q[s] <= res_mul_d;
        end else if (s == N + 1) begin
          ctl_q[s] <= ctl_div_d;
          res_q[s] <= res_div_d;
        end else begin
          ctl_q[s] <= ctl_q[s-1];
          res_q[s] <= res_q[s-1];
        end
      end
    end
  end

  assign m_axis_tvalid_o = vld_q[P-1];
  assign m_axis_tdata_o  = OUTB'(res_q[P-1]);
  assign m_axis_tuser_o  = {ctl_q[P-1].sat, ctl_q[P-1].dz, ctl_q[P-1].cmp};

  `include "q24_8_fixed_point_alu_core_assert.svh"

  `Q24A_ASSERT_IMP(a_dz_sat, m_axis_tvalid_o && m_axis_tuser_o[1], m_axis_tuser_o[2])
  `Q24A_ASSERT_IMP(a_cmp_zero, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == '0)
  `Q24A_ASSERT_IMP(a_cmp_nosat, m_axis_tvalid_o && m_axis_tuser_o[0], !m_axis_tuser_o[2])
  `Q24A_ASSERT_NXT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

@@ design/q24a_div.sv @@
// Restoring divider, one quotient bit per register stage
module q24a_div #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [WORD_BITS-1:0]           mag_a_i,
  input  logic [WORD_BITS-1:0]           mag_b_i,
  output logic [WORD_BITS+FRAC_BITS-1:0] quot_o,
  output logic [WORD_BITS-1:0]           rem_o,
  output logic [WORD_BITS-1:0]           divisor_o
);
  localparam int unsigned N = WORD_BITS + FRAC_BITS;

  logic [WORD_BITS-1:0] rem_q [N];
  logic [N-1:0]         dvd_q [N];
  logic [N-1:0]         quo_q [N];
  logic [WORD_BITS-1:0] dsr_q [N];

  logic [WORD_BITS-1:0] rem_d [N];
  logic [N-1:0]         dvd_d [N];
  logic [N-1:0]         quo_d [N];
  logic [WORD_BITS-1:0] dsr_d [N];

  always_comb begin
    logic [WORD_BITS-1:0] r_in;
    logic [N-1:0]         d_in;
    logic [N-1:0]         q_in;
    logic [WORD_BITS-1:0] b_in;
    logic [WORD_BITS:0]   t;
    logic                 ge;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        r_in = '0;
        d_in = {mag_a_i, {FRAC_BITS{1'b0}}};
        q_in = '0;
        b_in = mag_b_i;
      end else begin
        r_in = rem_q[s-1];
        d_in = dvd_q[s-1];
        q_in = quo_q[s-1];
        b_in = dsr_q[s-1];
      end
      t  = {r_in, d_in[N-1]};
      ge = (t >= {1'b0, b_in});
      rem_d[s] = ge ? WORD_BITS'(t - {1'b0, b_in}) : WORD_BITS'(t);
      dvd_d[s] = d_in << 1;
      quo_d[s] = {q_in[N-2:0], ge};
      dsr_d[s] = b_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s] <= rem_d[s];
        dvd_q[s] <= dvd_d[s];
        quo_q[s] <= quo_d[s];
        dsr_q[s] <= dsr_d[s];
      end
    end
  end

  assign quot_o    = quo_q[N-1];
  assign rem_o     = rem_q[N-1];
  assign divisor_o = dsr_q[N-1];

endmodule
